FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and helpers of the text console writer: request and
// result items, command codes, character constants, controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Request item
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] line;
    } req_t;

    // Result item
    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_line;
        logic [7:0] color_attribute;
        logic [7:0] cell_char;
        logic [7:0] cell_attribute;
        logic       position_error;
        logic       scrolled;
    } rsp_t;

    // Command codes
    localparam logic [2:0] MODE_PRINT = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_BACK  = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    // Characters and attributes
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_ESCAPE    = 8'h1B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ERROR     = 8'h45;
    localparam logic [7:0] ATTR_DEFAULT = 8'h0F;
    localparam logic [7:0] ATTR_ERROR   = 8'hF4;

    // Escape sequence progress
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_BG   = 2'd1;
    localparam logic [1:0] ESC_FG   = 2'd2;

    // Store sweeps
    typedef enum logic [1:0] {
        SW_NONE,
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } sweep_t;

    // Controller to datapath
    typedef struct packed {
        logic   load_item;
        logic   exec;
        logic   load_out;
        sweep_t sweep;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic exec_scroll;
        logic exec_clear;
        logic sweep_last;
    } stat_t;

    // Hex digit value, non-digits give zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine: screen store of character/attribute cells, cursor,
// current color and color escape handling, with one result per item.
// ----------------------------------------------------------------------------
//  channel | signals                       | carries
//  --------+-------------------------------+---------------------------------
//  req     | req_valid, req_ready, req     | mode, char_code, column, line
//  rsp     | rsp_valid, rsp_ready, rsp     | cursor, color, cell read, flags
//
//  Ordinary items pass through accept, then execute, then finish; the result
//  register loads in the finish state, where the next item may be accepted.
//  Clear and a scrolling print add a sweep of the screen store, one cell per
//  cycle; after reset a clearing pass zeroes the store first.
//  A result not taken holds in the output register and holds back the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire tcw_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output tcw_pkg::rsp_t      rsp
);

    tcw_pkg::ctrl_t ctrl;
    tcw_pkg::stat_t stat;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: accepts items, runs the execute step, the clear, scroll and
// reset sweeps of the screen store, and hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tcw_pkg::stat_t stat,
    output tcw_pkg::ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_CLEAR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Ready in idle, or while a result is handed over
    always_comb
    begin
        req_ready = (state_reg == S_IDLE) || (state_reg == S_FINISH && stat.slot_free);
        accept    = req_valid && req_ready;
    end

    // Commands and next state
    always_comb
    begin
        ctrl.load_item = accept;
        ctrl.exec      = 1'b0;
        ctrl.load_out  = 1'b0;
        ctrl.sweep     = tcw_pkg::SW_NONE;
        state_next     = state_reg;
        case (state_reg)
            S_INIT:
            begin
                ctrl.sweep = tcw_pkg::SW_INIT;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (stat.exec_scroll)
                    state_next = S_SCROLL;
                else if (stat.exec_clear)
                    state_next = S_CLEAR;
                else
                    state_next = S_FINISH;
            end
            S_SCROLL:
            begin
                ctrl.sweep = tcw_pkg::SW_SCROLL;
                if (stat.sweep_last)
                    state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                ctrl.sweep = tcw_pkg::SW_CLEAR;
                if (stat.sweep_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.slot_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, color and escape registers, sweep counter and the
// result register of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tcw_pkg::ctrl_t ctrl,
    output tcw_pkg::stat_t     stat,
    input  wire tcw_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output tcw_pkg::rsp_t      rsp
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int POS_W  = $clog2(31 * COLUMNS + 128);

    localparam logic [6:0]        LAST_COL  = 7'(COLUMNS - 1);
    localparam logic [4:0]        LAST_ROW  = 5'(ROWS - 1);
    localparam logic [POS_W-1:0]  COLS_P    = POS_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [CNT_W-1:0]  CNT_FILL  = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0]  CNT_SCR   = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0]  KEEP_END  = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0]  CNT_COLS  = CNT_W'(COLUMNS);

    // Screen store and its read register
    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;

    tcw_pkg::req_t    item_reg;
    logic [6:0]       col_reg, col_next;
    logic [4:0]       row_reg, row_next;
    logic [POS_W-1:0] cell_reg, cell_next;
    logic [7:0]       attr_reg, attr_next;
    logic [1:0]       esc_reg, esc_next;
    logic [7:0]       saved_reg, saved_next;
    logic             err_reg, rd_ok_reg, scr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg;
    tcw_pkg::rsp_t    out_reg;

    // Execute step signals
    logic              on_screen;
    logic              do_emit;
    logic [7:0]        ech;
    logic [6:0]        ecol;
    logic [4:0]        erow;
    logic [ADDR_W-1:0] eaddr;
    logic              e_we, e_err, e_scr, e_clear, e_rd;
    logic [ADDR_W-1:0] e_waddr, e_raddr;
    logic [15:0]       e_wdata;
    logic [POS_W-1:0]  rd_pos;

    // Memory port controls
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [15:0]       wdata;
    logic [CNT_W-1:0]  cnt_prev, cnt_ahead;

    // Execute: decode the item against current state
    always_comb
    begin
        on_screen  = (col_reg <= LAST_COL) && (row_reg <= LAST_ROW);
        col_next   = col_reg;
        row_next   = row_reg;
        attr_next  = attr_reg;
        esc_next   = esc_reg;
        saved_next = saved_reg;
        do_emit    = 1'b0;
        ech        = item_reg.char_code;
        ecol       = col_reg;
        erow       = row_reg;
        eaddr      = cell_reg[ADDR_W-1:0];
        e_we       = 1'b0;
        e_waddr    = eaddr;
        e_wdata    = 16'h0000;
        e_err      = 1'b0;
        e_scr      = 1'b0;
        e_clear    = 1'b0;
        e_rd       = 1'b0;
        rd_pos     = POS_W'(item_reg.line) * COLS_P + POS_W'(item_reg.column);
        e_raddr    = rd_pos[ADDR_W-1:0];

        case (item_reg.mode)
            tcw_pkg::MODE_PRINT:
            begin
                do_emit = 1'b1;
            end
            tcw_pkg::MODE_SET:
            begin
                col_next = item_reg.column;
                row_next = item_reg.line;
            end
            tcw_pkg::MODE_BACK:
            begin
                ech = tcw_pkg::CH_BACKSPACE;
                if (!on_screen)
                begin
                    do_emit = 1'b1;
                end
                else if (cell_reg != '0)
                begin
                    // step back one cell, wrapping to the previous row
                    do_emit = 1'b1;
                    eaddr   = cell_reg[ADDR_W-1:0] - ADDR_W'(1);
                    if (col_reg == 7'd0)
                    begin
                        ecol = LAST_COL;
                        erow = row_reg - 5'd1;
                    end
                    else
                    begin
                        ecol = col_reg - 7'd1;
                    end
                end
            end
            tcw_pkg::MODE_CLEAR:
            begin
                col_next = 7'd0;
                row_next = 5'd0;
                e_clear  = 1'b1;
            end
            tcw_pkg::MODE_READ:
            begin
                e_rd = (item_reg.column <= LAST_COL) && (item_reg.line <= LAST_ROW);
            end
            default:
            begin
            end
        endcase

        if (do_emit)
        begin
            if (!on_screen)
            begin
                // off screen: flag the last cell
                e_we    = 1'b1;
                e_waddr = LAST_CELL;
                e_wdata = {tcw_pkg::ATTR_ERROR, tcw_pkg::CH_ERROR};
                e_err   = 1'b1;
            end
            else
            begin
                col_next = ecol;
                row_next = erow;
                e_waddr  = eaddr;
                if (ech == tcw_pkg::CH_NEWLINE)
                begin
                    col_next = 7'd0;
                    if (erow == LAST_ROW)
                        e_scr = 1'b1;
                    else
                        row_next = erow + 5'd1;
                end
                else if (ech == tcw_pkg::CH_ESCAPE)
                begin
                    esc_next = tcw_pkg::ESC_FG;
                end
                else if (esc_reg == tcw_pkg::ESC_FG)
                begin
                    saved_next = ech;
                    esc_next   = tcw_pkg::ESC_BG;
                end
                else if (esc_reg == tcw_pkg::ESC_BG)
                begin
                    attr_next = {tcw_pkg::hex_digit(ech), tcw_pkg::hex_digit(saved_reg)};
                    esc_next  = tcw_pkg::ESC_IDLE;
                end
                else if (ech == tcw_pkg::CH_BACKSPACE)
                begin
                    e_we    = 1'b1;
                    e_wdata = {attr_reg, tcw_pkg::CH_SPACE};
                end
                else
                begin
                    e_we    = 1'b1;
                    e_wdata = {attr_reg, ech};
                    if (ecol == LAST_COL)
                    begin
                        col_next = 7'd0;
                        if (erow == LAST_ROW)
                            e_scr = 1'b1;
                        else
                            row_next = erow + 5'd1;
                    end
                    else
                    begin
                        col_next = ecol + 7'd1;
                    end
                end
            end
        end

        cell_next = POS_W'(row_next) * COLS_P + POS_W'(col_next);
    end

    // Sweep counter
    always_comb
    begin
        case (ctrl.sweep)
            tcw_pkg::SW_INIT:   stat.sweep_last = (cnt_reg == CNT_FILL);
            tcw_pkg::SW_CLEAR:  stat.sweep_last = (cnt_reg == CNT_FILL);
            tcw_pkg::SW_SCROLL: stat.sweep_last = (cnt_reg == CNT_SCR);
            default:            stat.sweep_last = 1'b0;
        endcase
        if (ctrl.sweep == tcw_pkg::SW_NONE)
            cnt_next = cnt_reg;
        else if (stat.sweep_last)
            cnt_next = '0;
        else
            cnt_next = cnt_reg + CNT_W'(1);
        stat.exec_scroll = e_scr;
        stat.exec_clear  = e_clear;
        stat.slot_free   = !out_valid_reg || rsp_ready;
    end

    // Memory port selection
    always_comb
    begin
        cnt_prev  = cnt_reg - CNT_W'(1);
        cnt_ahead = cnt_reg + CNT_COLS;
        we        = 1'b0;
        waddr     = e_waddr;
        wdata     = e_wdata;
        re        = 1'b0;
        raddr     = e_raddr;
        case (ctrl.sweep)
            tcw_pkg::SW_INIT:
            begin
                we    = 1'b1;
                waddr = cnt_reg[ADDR_W-1:0];
                wdata = 16'h0000;
            end
            tcw_pkg::SW_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[ADDR_W-1:0];
                wdata = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::SW_SCROLL:
            begin
                // read one row ahead, write back the cell read last cycle
                re    = (cnt_reg < KEEP_END);
                raddr = cnt_ahead[ADDR_W-1:0];
                we    = (cnt_reg != '0);
                waddr = cnt_prev[ADDR_W-1:0];
                wdata = (cnt_reg <= KEEP_END) ? rd_data_reg : 16'h0000;
            end
            default:
            begin
                we = ctrl.exec && e_we;
                re = ctrl.exec && e_rd;
            end
        endcase
    end

    // Screen store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
            item_reg <= req;
        if (ctrl.load_out)
        begin
            out_reg.cursor_column   <= col_reg;
            out_reg.cursor_line     <= row_reg;
            out_reg.color_attribute <= attr_reg;
            out_reg.cell_char       <= rd_ok_reg ? rd_data_reg[7:0] : 8'h00;
            out_reg.cell_attribute  <= rd_ok_reg ? rd_data_reg[15:8] : 8'h00;
            out_reg.position_error  <= err_reg;
            out_reg.scrolled        <= scr_reg;
        end
    end

    // Console state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 7'd0;
            row_reg       <= 5'd0;
            cell_reg      <= '0;
            attr_reg      <= tcw_pkg::ATTR_DEFAULT;
            esc_reg       <= tcw_pkg::ESC_IDLE;
            saved_reg     <= tcw_pkg::CH_SPACE;
            err_reg       <= 1'b0;
            scr_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                cell_reg  <= cell_next;
                attr_reg  <= attr_next;
                esc_reg   <= esc_next;
                saved_reg <= saved_next;
                err_reg   <= e_err;
                scr_reg   <= e_scr;
                rd_ok_reg <= e_rd;
            end
            cnt_reg <= cnt_next;
            if (ctrl.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
